### design/adf_pkg.sv
// Shared types and constants for the ASCII decimal to fixed-point unit.
// Used by the parser front end, the job queue, the divider back end and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adf_pkg;

  // Number format
  localparam int INT_BITS        = 16;
  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 12;
  localparam int VALUE_W         = INT_BITS + FRAC_BITS + 1;
  localparam int MAG_W           = INT_BITS + FRAC_BITS;
  // Twelve decimal digits need 40 bits
  localparam int FRAC_ACC_W      = 40;
  localparam int CNT_W           = 4;
  localparam int ITER_W          = $clog2(FRAC_BITS);

  // Job queue between parser and divider
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Powers of ten, indexed by fraction digit count
  localparam logic [FRAC_ACC_W-1:0] POW10 [0:12] = '{
    40'd1,
    40'd10,
    40'd100,
    40'd1000,
    40'd10000,
    40'd100000,
    40'd1000000,
    40'd10000000,
    40'd100000000,
    40'd1000000000,
    40'd10000000000,
    40'd100000000000,
    40'd1000000000000
  };

  // Parser phase
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_TRAIL,
    PH_ERR
  } phase_e;

  // Divider back end state
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_e;

  // One parsed number, waiting for scaling
  typedef struct packed {
    logic                  ok;
    logic                  negative;
    logic                  overflow;
    logic [INT_BITS-1:0]   int_part;
    logic [FRAC_ACC_W-1:0] frac_acc;
    logic [CNT_W-1:0]      frac_count;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

`default_nettype wire

### design/adf_front.sv
// Parser front end: takes one character per transaction and builds a job at end of string.
// Depends on adf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adf_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            ch_i,
  input  wire logic                  is_end_i,
  input  wire adf_pkg::queue_status_t q_status_i,
  output logic                       push_o,
  output adf_pkg::job_t              job_o
);

  localparam int IW = adf_pkg::INT_BITS + 4;

  adf_pkg::phase_e phase_q, phase_d;
  logic                           negative_q, seen_q, ovf_q;
  logic [adf_pkg::INT_BITS-1:0]   int_q;
  logic [adf_pkg::FRAC_ACC_W-1:0] frac_q;
  logic [adf_pkg::CNT_W-1:0]      cnt_q;

  logic       accept, is_end, is_space, is_digit, is_sign;
  logic [7:0] diff;
  logic [3:0] digit;
  logic [IW-1:0] int_next;
  logic [adf_pkg::FRAC_ACC_W-1:0] frac_next;
  logic int_dig, frac_dig, dot_take, sign_take;

  // Hold every character while the job queue is full
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Character classes
  assign is_end   = is_end_i || (ch_i == adf_pkg::CH_NUL);
  assign is_space = (ch_i == adf_pkg::CH_SPACE) ||
                    (ch_i inside {[adf_pkg::CH_TAB:adf_pkg::CH_CR]});
  assign is_digit = ch_i inside {[adf_pkg::CH_ZERO:adf_pkg::CH_NINE]};
  assign is_sign  = (ch_i == adf_pkg::CH_MINUS) || (ch_i == adf_pkg::CH_PLUS);
  assign diff     = ch_i - adf_pkg::CH_ZERO;
  assign digit    = diff[3:0];

  // Times ten plus digit, as shift and add
  assign int_next  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + IW'(digit);
  assign frac_next = (frac_q << 3) + (frac_q << 1) + adf_pkg::FRAC_ACC_W'(digit);

  // Phase transitions
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      adf_pkg::PH_LEAD: begin
        if (is_space) phase_d = adf_pkg::PH_LEAD;
        else if (is_sign || is_digit) phase_d = adf_pkg::PH_INT;
        else if (ch_i == adf_pkg::CH_DOT) phase_d = adf_pkg::PH_FRAC;
        else phase_d = adf_pkg::PH_ERR;
      end
      adf_pkg::PH_INT: begin
        if (is_digit) phase_d = adf_pkg::PH_INT;
        else if (ch_i == adf_pkg::CH_DOT) phase_d = adf_pkg::PH_FRAC;
        else if (is_space) phase_d = adf_pkg::PH_TRAIL;
        else phase_d = adf_pkg::PH_ERR;
      end
      adf_pkg::PH_FRAC: begin
        if (is_digit) phase_d = adf_pkg::PH_FRAC;
        else if (is_space) phase_d = adf_pkg::PH_TRAIL;
        else phase_d = adf_pkg::PH_ERR;
      end
      adf_pkg::PH_TRAIL: begin
        if (!is_space) phase_d = adf_pkg::PH_ERR;
      end
      default: phase_d = adf_pkg::PH_ERR;
    endcase
  end

  // What this character does to the accumulators
  always_comb begin
    int_dig   = is_digit && (phase_q == adf_pkg::PH_LEAD || phase_q == adf_pkg::PH_INT);
    frac_dig  = is_digit && (phase_q == adf_pkg::PH_FRAC) &&
                (cnt_q < adf_pkg::CNT_W'(adf_pkg::MAX_FRAC_DIGITS));
    dot_take  = (ch_i == adf_pkg::CH_DOT) &&
                (phase_q == adf_pkg::PH_LEAD || phase_q == adf_pkg::PH_INT);
    sign_take = is_sign && (phase_q == adf_pkg::PH_LEAD);
  end

  // Parser state; cleared after each end of string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= adf_pkg::PH_LEAD;
      negative_q <= 1'b0;
      seen_q     <= 1'b0;
      ovf_q      <= 1'b0;
      int_q      <= '0;
      frac_q     <= '0;
      cnt_q      <= '0;
    end else if (accept) begin
      if (is_end) begin
        phase_q    <= adf_pkg::PH_LEAD;
        negative_q <= 1'b0;
        seen_q     <= 1'b0;
        ovf_q      <= 1'b0;
        int_q      <= '0;
        frac_q     <= '0;
        cnt_q      <= '0;
      end else begin
        phase_q <= phase_d;
        if (sign_take) negative_q <= (ch_i == adf_pkg::CH_MINUS);
        if (int_dig || dot_take) seen_q <= 1'b1;
        if (int_dig && !ovf_q) begin
          if (int_next[IW-1:adf_pkg::INT_BITS] != '0) begin
            ovf_q <= 1'b1;
            int_q <= '1;
          end else begin
            int_q <= int_next[adf_pkg::INT_BITS-1:0];
          end
        end
        if (frac_dig) begin
          frac_q <= frac_next;
          cnt_q  <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Job handed to the queue at end of string
  assign push_o = accept && is_end;
  always_comb begin
    job_o.ok         = (phase_q != adf_pkg::PH_ERR) && seen_q;
    job_o.negative   = negative_q;
    job_o.overflow   = ovf_q;
    job_o.int_part   = int_q;
    job_o.frac_acc   = frac_q;
    job_o.frac_count = cnt_q;
  end

endmodule

`default_nettype wire

### design/adf_queue.sv
// Short job queue between the parser and the divider.
// Depends on adf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adf_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire adf_pkg::job_t wr_job_i,
  input  wire logic          pop_i,
  output adf_pkg::job_t      rd_job_o,
  output adf_pkg::queue_status_t status_o
);

  adf_pkg::job_t entry_q [adf_pkg::QUEUE_DEPTH];
  logic [adf_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [adf_pkg::QCNT_W-1:0] count_q;

  assign status_o.full      = (count_q == adf_pkg::QCNT_W'(adf_pkg::QUEUE_DEPTH));
  assign status_o.not_empty = (count_q != '0);
  assign rd_job_o           = entry_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= wr_job_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/adf_back.sv
// Divider back end: scales the fraction digits by restoring division, applies sign, holds result.
// Depends on adf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adf_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire adf_pkg::queue_status_t q_status_i,
  input  wire adf_pkg::job_t         job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       accepted_o,
  output logic signed [adf_pkg::VALUE_W-1:0] value_o,
  output logic                       saturated_o
);

  localparam int FW = adf_pkg::FRAC_ACC_W;

  adf_pkg::back_state_e state_q, state_d;

  logic                         ok_q, neg_q, ovf_q;
  logic [adf_pkg::INT_BITS-1:0] int_q;
  logic [FW-1:0]                rem_q, den_q;
  logic [adf_pkg::FRAC_BITS-1:0] quot_q;
  logic [adf_pkg::ITER_W-1:0]   iter_q;

  logic                         out_valid_q, accepted_q, saturated_q;
  logic [adf_pkg::VALUE_W-1:0]  value_q;

  logic          out_free, load_out, last_iter;
  logic [FW:0]   rem2, rem_sub;
  logic          ge;
  logic [adf_pkg::MAG_W-1:0]   mag;
  logic [adf_pkg::VALUE_W-1:0] mag_x, value_d;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_iter = (iter_q == adf_pkg::ITER_W'(adf_pkg::FRAC_BITS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      adf_pkg::BK_IDLE: begin
        if (q_status_i.not_empty) begin
          if (job_i.ok && !job_i.overflow) state_d = adf_pkg::BK_DIV;
          else state_d = adf_pkg::BK_FIN;
        end
      end
      adf_pkg::BK_DIV: begin
        if (last_iter) state_d = adf_pkg::BK_FIN;
      end
      adf_pkg::BK_FIN: begin
        if (out_free) state_d = adf_pkg::BK_IDLE;
      end
      default: state_d = adf_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      adf_pkg::BK_IDLE: pop_o    = q_status_i.not_empty;
      adf_pkg::BK_FIN:  load_out = out_free;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // One restoring division step: shift, compare, subtract
  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, den_q};
  assign ge      = (rem2 >= {1'b0, den_q});

  // Magnitude, then sign
  assign mag     = ovf_q ? '1 : {int_q, quot_q};
  assign mag_x   = {1'b0, mag};
  assign value_d = !ok_q ? '0 : (neg_q ? ('0 - mag_x) : mag_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= adf_pkg::BK_IDLE;
    else         state_q <= state_d;
  end

  // Job datapath; the fraction digits are always below their power of ten
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q   <= job_i.ok;
      neg_q  <= job_i.negative;
      ovf_q  <= job_i.overflow;
      int_q  <= job_i.int_part;
      rem_q  <= job_i.frac_acc;
      den_q  <= adf_pkg::POW10[job_i.frac_count];
      quot_q <= '0;
      iter_q <= '0;
    end else if (state_q == adf_pkg::BK_DIV) begin
      quot_q <= {quot_q[adf_pkg::FRAC_BITS-2:0], ge};
      rem_q  <= ge ? rem_sub[FW-1:0] : rem2[FW-1:0];
      iter_q <= iter_q + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      accepted_q  <= ok_q;
      saturated_q <= ok_q && ovf_q;
      value_q     <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign saturated_o = saturated_q;
  assign value_o     = value_q;

  // Remainder stays below the divisor while dividing
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == adf_pkg::BK_DIV |-> rem_q < den_q)
    else $error("remainder not below divisor");

  // A saturated result is always an accepted one
  a_sat_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && saturated_q |-> accepted_q)
    else $error("saturated flag on rejected result");

  // Rejected results carry a zero value
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !accepted_q |-> value_q == '0)
    else $error("rejected result with nonzero value");

  // Division ends only after the last quotient bit
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == adf_pkg::BK_DIV && state_d == adf_pkg::BK_FIN |-> last_iter)
    else $error("division left early");

endmodule

`default_nettype wire

### design/ascii_decimal_to_fixed_unit.sv
// ASCII decimal string to signed fixed-point converter, top level.
// Instantiates adf_front, adf_queue and adf_back; depends on adf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Characters are taken one per cycle; in_stall_o rises only when both job queue entries
// are occupied. Each end of string (is_end_i or a zero byte) becomes a job for the back
// end, which loads it, scales the fraction digits by restoring division (skipped for
// rejected or overflowing jobs) and signs the value into the output register. The back
// end takes one job at a time and pops the next only after the last result is loaded, so
// short strings can be held up by the divider. value_o is two's complement with a sign
// bit, 16 integer and 32 fraction bits; integer overflow clamps the magnitude to all ones
// and raises saturated_o.
module ascii_decimal_to_fixed_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        is_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic signed [adf_pkg::VALUE_W-1:0] value_o,
  output logic             saturated_o
);

  adf_pkg::job_t          push_job, pop_job;
  adf_pkg::queue_status_t q_status;
  logic                   push, pop;

  adf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .is_end_i   (is_end_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  adf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_job_i (push_job),
    .pop_i    (pop),
    .rd_job_o (pop_job),
    .status_o (q_status)
  );

  adf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .accepted_o  (accepted_o),
    .value_o     (value_o),
    .saturated_o (saturated_o)
  );

endmodule

`default_nettype wire

### tb/adf_number_checker.sv
// Checker for the ASCII decimal to fixed-point unit: follows both channels,
// predicts each number from the characters it sees and compares the results.
// Depends on adf_pkg for the number format and the character codes.
`timescale 1ns / 1ps

module adf_number_checker
  import adf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [7:0]         ch_i,
  input  wire logic               is_end_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               accepted_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic               saturated_i,
  output int                      errors_o,
  output int                      pending_o
);

  typedef struct packed {
    logic               accepted;
    logic [VALUE_W-1:0] value;
    logic               saturated;
  } number_t;

  // Parser state as the block should hold it
  phase_e                phase;
  logic                  negative;
  logic                  seen_digit;
  logic [INT_BITS-1:0]   int_acc;
  logic [FRAC_ACC_W-1:0] frac_acc;
  int                    frac_count;
  logic                  int_overflow;

  number_t expected_numbers[$];
  int      numbers_checked;

  task automatic report_mismatch(input string what);
    $display("[%0t] number %0d: %s", $time, numbers_checked, what);
    errors_o++;
  endtask

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_parser();
    phase        = PH_LEAD;
    negative     = 1'b0;
    seen_digit   = 1'b0;
    int_acc      = '0;
    frac_acc     = '0;
    frac_count   = 0;
    int_overflow = 1'b0;
  endtask

  // Integer digits clamp at all ones and stop accumulating once clamped
  task automatic add_int_digit(input logic [7:0] c);
    logic [31:0] next;
    seen_digit = 1'b1;
    if (!int_overflow) begin
      next = int_acc * 10 + (c - CH_ZERO);
      if (next > {INT_BITS{1'b1}}) begin
        int_overflow = 1'b1;
        int_acc      = {INT_BITS{1'b1}};
      end else begin
        int_acc = next[INT_BITS-1:0];
      end
    end
  endtask

  // Fraction digits beyond the kept count are swallowed
  task automatic add_frac_digit(input logic [7:0] c);
    if (frac_count < MAX_FRAC_DIGITS) begin
      frac_acc = frac_acc * 10 + (c - CH_ZERO);
      frac_count++;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (phase)
      PH_LEAD: begin
        if (c == CH_MINUS || c == CH_PLUS) begin
          negative = (c == CH_MINUS);
          phase    = PH_INT;
        end else if (is_digit(c)) begin
          add_int_digit(c);
          phase = PH_INT;
        end else if (c == CH_DOT) begin
          seen_digit = 1'b1;
          phase      = PH_FRAC;
        end else if (!is_space(c)) begin
          phase = PH_ERR;
        end
      end
      PH_INT: begin
        if (is_digit(c)) begin
          add_int_digit(c);
        end else if (c == CH_DOT) begin
          seen_digit = 1'b1;
          phase      = PH_FRAC;
        end else if (is_space(c)) begin
          phase = PH_TRAIL;
        end else begin
          phase = PH_ERR;
        end
      end
      PH_FRAC: begin
        if (is_digit(c)) begin
          add_frac_digit(c);
        end else if (is_space(c)) begin
          phase = PH_TRAIL;
        end else begin
          phase = PH_ERR;
        end
      end
      PH_TRAIL: begin
        if (!is_space(c)) phase = PH_ERR;
      end
      default: begin
        phase = PH_ERR;
      end
    endcase
  endtask

  // floor(digits * 2^FRAC_BITS / 10^count); digits is always below 10^count
  function automatic logic [FRAC_BITS-1:0] scale_fraction(input logic [FRAC_ACC_W-1:0] digits,
                                                          input int count);
    logic [FRAC_ACC_W+FRAC_BITS-1:0] num;
    logic [FRAC_ACC_W+FRAC_BITS-1:0] den;
    logic [FRAC_ACC_W+FRAC_BITS-1:0] quo;
    den = 1;
    for (int i = 0; i < count; i++) den = den * 10;
    num = {digits, {FRAC_BITS{1'b0}}};
    quo = num / den;
    return quo[FRAC_BITS-1:0];
  endfunction

  function automatic number_t finish_number();
    number_t          r;
    logic [MAG_W-1:0] mag;
    r = '0;
    if (phase != PH_ERR && seen_digit) begin
      mag = int_overflow ? {MAG_W{1'b1}} : {int_acc, scale_fraction(frac_acc, frac_count)};
      r.accepted  = 1'b1;
      r.value     = negative ? -{1'b0, mag} : {1'b0, mag};
      r.saturated = int_overflow;
    end
    return r;
  endfunction

  // Results first: none can stem from a character taken at the same edge
  always @(posedge clk_i) begin
    number_t want;
    if (!rst_ni) begin
      clear_parser();
      expected_numbers.delete();
      errors_o        = 0;
      numbers_checked = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_numbers.size() == 0) begin
          report_mismatch("result transaction with no number pending");
        end else begin
          want = expected_numbers.pop_front();
          if (accepted_i !== want.accepted)
            report_mismatch($sformatf("accepted %b, expected %b", accepted_i, want.accepted));
          if (value_i !== want.value)
            report_mismatch($sformatf("value %h, expected %h", value_i, want.value));
          if (saturated_i !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b", saturated_i,
                                      want.saturated));
        end
        numbers_checked++;
      end
      if (in_valid_i && !in_stall_i) begin
        if (is_end_i || ch_i == CH_NUL) begin
          expected_numbers.push_back(finish_number());
          clear_parser();
        end else begin
          parse_char(ch_i);
        end
      end
    end
    pending_o = expected_numbers.size();
  end

endmodule

### tb/tb.sv
// Top of the testbench: drives character strings into the converter, stalls its
// result side at random and reports the verdict. Depends on adf_pkg, the DUT
// top level ascii_decimal_to_fixed_unit and adf_number_checker.
`timescale 1ns / 1ps

module tb;
  import adf_pkg::*;

  localparam int TARGET_CHARS = 1500;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         ch_i;
  logic               is_end_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               accepted_o;
  logic [VALUE_W-1:0] value_o;
  logic               saturated_o;

  int check_errors;
  int numbers_pending;
  int chars_sent;
  int idle_cycles;
  bit in_idle_en;
  bit out_idle_en;

  ascii_decimal_to_fixed_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .is_end_i    (is_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .accepted_o  (accepted_o),
    .value_o     (value_o),
    .saturated_o (saturated_o)
  );

  adf_number_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .ch_i        (ch_i),
    .is_end_i    (is_end_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .accepted_i  (accepted_o),
    .value_i     (value_o),
    .saturated_i (saturated_o),
    .errors_o    (check_errors),
    .pending_o   (numbers_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: hold each offered result for a random number of cycles
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_valid_o) begin
        hold = out_idle_en ? $urandom_range(0, 7) : 0;
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
        do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      end
    end
  end

  // One character transaction; called and returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    gap = in_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    is_end_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // A string closed either by the end flag (with a junk byte) or by a zero byte
  task automatic send_bytes(input logic [7:0] text[$], input bit by_flag);
    foreach (text[i]) send_char(text[i], 1'b0);
    if (by_flag) send_char(8'($urandom_range(0, 255)), 1'b1);
    else         send_char(CH_NUL, 1'b0);
  endtask

  task automatic send_text(input string s, input bit by_flag);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_bytes(text, by_flag);
  endtask

  function automatic logic [7:0] pick_space();
    if ($urandom_range(0, 1)) return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  initial begin : stimulus
    logic [7:0]  text[$];
    logic [7:0]  cr_text[$];
    string       num_str;
    int unsigned num;
    int unsigned kind;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ch_i        = '0;
    is_end_i    = 1'b0;
    chars_sent  = 0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lone dot, sign alone, space after sign, overflow after CR,
    // sign and fraction with tab before a zero byte, and an out-of-range byte
    send_text(".", 1'b1);
    send_text("-", 1'b0);
    send_text("- 5", 1'b1);
    cr_text = '{CH_CR, "9", "9", "9", "9", "9"};
    send_bytes(cr_text, 1'b1);
    send_text({"+1.5", string'(CH_TAB)}, 1'b0);
    text = '{8'hff};
    send_bytes(text, 1'b1);

    // Random strings: mostly well formed, some broken, some pure noise
    while (chars_sent < TARGET_CHARS) begin
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      text.delete();
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        repeat ($urandom_range(0, 2)) text.push_back(pick_space());
        case ($urandom_range(0, 2))
          1:       text.push_back(CH_PLUS);
          2:       text.push_back(CH_MINUS);
          default: ;
        endcase
        if ($urandom_range(0, 4) == 0) text.push_back(CH_ZERO);
        case ($urandom_range(0, 4))
          0:       num_str = "";
          1:       num_str = $sformatf("%0d", $urandom_range(0, 999));
          2:       num_str = $sformatf("%0d", $urandom_range(65530, 65540));
          3:       num_str = $sformatf("%0d", $urandom_range(60000, 70000));
          default: begin
            num     = $urandom;
            num_str = $sformatf("%0d", num);
          end
        endcase
        for (int i = 0; i < num_str.len(); i++) text.push_back(num_str[i]);
        if ($urandom_range(0, 3) != 0) begin
          text.push_back(CH_DOT);
          repeat ($urandom_range(0, 15)) text.push_back(pick_digit());
        end
        repeat ($urandom_range(0, 2)) text.push_back(pick_space());
        // Broken string: one stray byte somewhere
        if (kind >= 6)
          text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
      end
      send_bytes(text, $urandom_range(0, 1));
    end
    in_valid_i <= 1'b0;

    // Drain: every number back, then a quiet stretch for strays
    while (numbers_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (check_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
